### design/mmnr_pkg.sv
// Shared constants for the min-max normalise and reverse block.
package mmnr_pkg;

	localparam int DEPTH_DEF       = 64;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int FRAC_BITS       = 16;
	localparam int SCALED_W        = FRAC_BITS + 1;

endpackage

### design/mmnr_if.sv
// Stream interfaces for samples in and normalised results out.
interface mmnr_in_if import mmnr_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          last;

	modport source (output valid, output sample, output last, input ready);
	modport sink   (input valid, input sample, input last, output ready);
endinterface

interface mmnr_out_if import mmnr_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int IDX_W       = $clog2(DEPTH_DEF)
) ();
	logic                          valid;
	logic                          ready;
	logic [IDX_W-1:0]              index;
	logic signed [SAMPLE_BITS-1:0] original;
	logic [SCALED_W-1:0]           scaled;
	logic signed [SAMPLE_BITS-1:0] mirrored;
	logic                          flat_range;
	logic                          overflowed;
	logic                          final_res;

	modport source (output valid, output index, output original, output scaled,
		output mirrored, output flat_range, output overflowed, output final_res,
		input ready);
	modport sink   (input valid, input index, input original, input scaled,
		input mirrored, input flat_range, input overflowed, input final_res,
		output ready);
endinterface

### design/mmnr_div.sv
// Restoring divider, one quotient bit per cycle: quot = floor(num * 2^16 / den), num <= den.
module mmnr_div import mmnr_pkg::*; #(
	parameter int W = SAMPLE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [W-1:0]        num,
	input  logic [W-1:0]        den,
	output logic                done,
	output logic [SCALED_W-1:0] quot
);
	localparam int STEP_W = $clog2(SCALED_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [W:0]        rem_q;
	logic [W-1:0]      den_q;
	logic [SCALED_W-1:0] quot_q;

	logic       ge;
	logic [W:0] rem_sub;

	assign ge      = rem_q >= {1'b0, den_q};
	assign rem_sub = ge ? (rem_q - {1'b0, den_q}) : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(SCALED_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
		end else if (busy_q) begin
			// remainder stays below den, so the shift fits in W+1 bits
			rem_q  <= {rem_sub[W-1:0], 1'b0};
			quot_q <= {quot_q[SCALED_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule

### design/min_max_normalize_reverse.sv
// Top level: sample buffer, running min/max and sequencer around a shared divider.
//
// Usage: samples arrive on the "samples" stream (sample, last). Each accepted
// transaction is stored in a DEPTH-entry buffer and updates the running
// minimum and maximum; samples beyond DEPTH are dropped and flagged.
// The transaction marked last starts emission: one result per stored sample on
// the "results" stream, in index order, with the stored sample, the sample at
// the mirrored position and (x-min)/(max-min) as unsigned Q1.16.
// Loading: ready is high in every load cycle.
// Emission: each result goes through buffer read, divider start, the 17-step
// bit-serial divider and output load; the divider is skipped when max equals min.
// Input ready is low from the last sample until the final result has been
// loaded into the output register.
// A stalled receiver holds the output register; the sequencer then waits with
// the next result finished. After the final result the block is empty again.
// Reset clears counters, min/max and flags; the buffer needs no clearing.
module min_max_normalize_reverse import mmnr_pkg::*; #(
	parameter int DEPTH       = DEPTH_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	mmnr_in_if.sink      samples,
	mmnr_out_if.source   results
);
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SB    = SAMPLE_BITS;

	localparam logic [2:0] ST_LOAD  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_START = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_PUT   = 3'd4;

	logic [2:0]           state_q;
	logic [CNT_W-1:0]     count_q;
	logic signed [SB-1:0] min_q;
	logic signed [SB-1:0] max_q;
	logic                 drop_q;
	logic [IDX_W-1:0]     idx_q;

	logic signed [SB-1:0] mem [DEPTH];
	logic signed [SB-1:0] rd_a_q;
	logic signed [SB-1:0] rd_b_q;

	logic                 oval_q;
	logic [IDX_W-1:0]     index_q;
	logic signed [SB-1:0] original_q;
	logic [SCALED_W-1:0]  scaled_q;
	logic signed [SB-1:0] mirrored_q;
	logic                 flat_q;
	logic                 ovf_q;
	logic                 final_q;

	logic             in_acc;
	logic             full;
	logic             flat;
	logic [IDX_W-1:0] last_idx;
	logic [IDX_W-1:0] mirror_idx;
	logic [SB:0]      range_x;
	logic [SB:0]      diff_x;
	logic             out_free;
	logic             put;
	logic             div_start;
	logic             div_done;
	logic [SCALED_W-1:0] div_quot;

	assign samples.ready = (state_q == ST_LOAD);
	assign in_acc        = samples.valid && samples.ready;
	assign full          = (count_q == CNT_W'(DEPTH));
	assign flat          = (min_q == max_q);
	assign last_idx      = IDX_W'(count_q - CNT_W'(1));
	assign mirror_idx    = last_idx - idx_q;
	assign range_x       = {max_q[SB-1], max_q} - {min_q[SB-1], min_q};
	assign diff_x        = {rd_a_q[SB-1], rd_a_q} - {min_q[SB-1], min_q};
	assign out_free      = !oval_q || results.ready;
	assign put           = (state_q == ST_PUT) && out_free;
	assign div_start     = (state_q == ST_START) && !flat;

	mmnr_div #(.W(SB)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (diff_x[SB-1:0]),
		.den    (range_x[SB-1:0]),
		.done   (div_done),
		.quot   (div_quot)
	);

	// sample buffer: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (in_acc && !full)
			mem[count_q[IDX_W-1:0]] <= samples.sample;
		if (state_q == ST_READ) begin
			rd_a_q <= mem[idx_q];
			rd_b_q <= mem[mirror_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			min_q   <= '0;
			max_q   <= '0;
			drop_q  <= 1'b0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (full) begin
							drop_q <= 1'b1;
						end else begin
							count_q <= count_q + CNT_W'(1);
							if (count_q == '0) begin
								min_q <= samples.sample;
								max_q <= samples.sample;
							end else if (samples.sample > max_q) begin
								max_q <= samples.sample;
							end else if (samples.sample < min_q) begin
								min_q <= samples.sample;
							end
						end
						if (samples.last) begin
							idx_q   <= '0;
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: state_q <= ST_START;
				ST_START: state_q <= flat ? ST_PUT : ST_DIV;
				ST_DIV: begin
					if (div_done)
						state_q <= ST_PUT;
				end
				ST_PUT: begin
					if (out_free) begin
						if (idx_q == last_idx) begin
							count_q <= '0;
							min_q   <= '0;
							max_q   <= '0;
							drop_q  <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= ST_READ;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			oval_q <= 1'b0;
		else if (put)
			oval_q <= 1'b1;
		else if (results.ready)
			oval_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (put) begin
			index_q    <= idx_q;
			original_q <= rd_a_q;
			mirrored_q <= rd_b_q;
			scaled_q   <= flat ? '0 : div_quot;
			flat_q     <= flat;
			ovf_q      <= drop_q;
			final_q    <= (idx_q == last_idx);
		end
	end

	assign results.valid      = oval_q;
	assign results.index      = index_q;
	assign results.original   = original_q;
	assign results.scaled     = scaled_q;
	assign results.mirrored   = mirrored_q;
	assign results.flat_range = flat_q;
	assign results.overflowed = ovf_q;
	assign results.final_res  = final_q;
endmodule

### design/mmnr_checker.sv
// Port-level assertions for min_max_normalize_reverse, attached by bind.
module mmnr_checker import mmnr_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                in_last,
	input logic                out_valid,
	input logic                out_ready,
	input logic [SCALED_W-1:0] out_scaled,
	input logic                out_flat_range
);
	localparam logic [SCALED_W-1:0] ONE_Q = SCALED_W'(1) << FRAC_BITS;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready)
		else $error("input taken during emission");

	a_flat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_flat_range |-> out_scaled == '0)
		else $error("flat range with nonzero scaled value");

	a_scaled_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_scaled <= ONE_Q)
		else $error("scaled value above 1.0");
endmodule

bind min_max_normalize_reverse mmnr_checker u_mmnr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (samples.valid),
	.in_ready       (samples.ready),
	.in_last        (samples.last),
	.out_valid      (results.valid),
	.out_ready      (results.ready),
	.out_scaled     (results.scaled),
	.out_flat_range (results.flat_range)
);

### dv/tb.sv
// Testbench for min_max_normalize_reverse: directed and random sample sets against a predictor.
module tb;
	import mmnr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH      = DEPTH_DEF;
	localparam int SBITS      = SAMPLE_BITS_DEF;
	localparam int IDX_W      = $clog2(DEPTH_DEF);
	localparam int ITEM_COUNT = 480;
	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYC  = 64;

	typedef struct {
		logic signed [SBITS-1:0] sample;
		logic                    last;
	} sample_item_t;

	typedef struct {
		logic [IDX_W-1:0]        index;
		logic signed [SBITS-1:0] original;
		logic [SCALED_W-1:0]     scaled;
		logic signed [SBITS-1:0] mirrored;
		logic                    flat_range;
		logic                    overflowed;
		logic                    final_res;
	} norm_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mmnr_in_if  #(.SAMPLE_BITS(SBITS)) samples_if ();
	mmnr_out_if #(.SAMPLE_BITS(SBITS), .IDX_W(IDX_W)) results_if ();

	min_max_normalize_reverse #(.DEPTH(DEPTH), .SAMPLE_BITS(SBITS)) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.results (results_if)
	);

	always #10 clk = ~clk;

	sample_item_t sample_queue[$];
	norm_result_t pending_results[$];
	int fail_count = 0;
	int items_queued = 0;

	// predictor state for the set being collected
	logic signed [SBITS-1:0] set_store [DEPTH];
	int unsigned set_len = 0;
	logic signed [SBITS-1:0] set_min = '0;
	logic signed [SBITS-1:0] set_max = '0;
	bit set_dropped = 1'b0;

	task automatic absorb_sample(input logic signed [SBITS-1:0] x, input logic is_last);
		norm_result_t r;
		bit flat;
		longint span;
		longint offs;
		if (set_len < DEPTH) begin
			set_store[set_len] = x;
			if (set_len == 0) begin
				set_min = x;
				set_max = x;
			end else if (x > set_max) begin
				set_max = x;
			end else if (x < set_min) begin
				set_min = x;
			end
			set_len++;
		end else begin
			set_dropped = 1'b1;
		end
		if (!is_last)
			return;
		flat = (set_max == set_min);
		span = longint'(set_max) - longint'(set_min);
		for (int unsigned i = 0; i < set_len; i++) begin
			offs = longint'(set_store[i]) - longint'(set_min);
			r.index      = i[IDX_W-1:0];
			r.original   = set_store[i];
			r.scaled     = flat ? '0 : SCALED_W'((offs << FRAC_BITS) / span);
			r.mirrored   = set_store[set_len - 1 - i];
			r.flat_range = flat;
			r.overflowed = set_dropped;
			r.final_res  = (i + 1 == set_len);
			pending_results.push_back(r);
		end
		set_len = 0;
		set_min = '0;
		set_max = '0;
		set_dropped = 1'b0;
	endtask

	// wait draw with occasional runs of back-to-back cycles
	function automatic int draw_wait(inout int quiet);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			quiet = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 8);
	endfunction

	task automatic push_item(input logic signed [SBITS-1:0] s, input logic l);
		sample_item_t it;
		it.sample = s;
		it.last = l;
		sample_queue.push_back(it);
		items_queued++;
	endtask

	function automatic logic signed [SBITS-1:0] draw_sample(input int mode,
		input logic signed [SBITS-1:0] base);
		case (mode)
			1: return base + SBITS'($urandom_range(0, 3));
			2: return base;
			3: begin
				case ($urandom_range(0, 4))
					0: return 16'sh8000;
					1: return 16'sh7FFF;
					2: return 16'sh0000;
					3: return 16'shFFFF;
					default: return SBITS'($urandom);
				endcase
			end
			default: return SBITS'($urandom);
		endcase
	endfunction

	task automatic queue_random_set(input int size);
		int mode;
		logic signed [SBITS-1:0] base;
		mode = $urandom_range(0, 3);
		base = SBITS'($urandom);
		for (int k = 0; k < size; k++)
			push_item(draw_sample(mode, base), k == size - 1);
	endtask

	task automatic check_field(input string name, input logic signed [32:0] exp_v,
		input logic signed [32:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	// driver
	int drv_gap = 0;
	int drv_quiet = 0;
	sample_item_t drv_item;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_if.valid  <= 1'b0;
			samples_if.sample <= '0;
			samples_if.last   <= 1'b0;
		end else begin
			if (samples_if.valid && samples_if.ready)
				absorb_sample(samples_if.sample, samples_if.last);
			if (!samples_if.valid || samples_if.ready) begin
				if (drv_gap > 0) begin
					drv_gap--;
					samples_if.valid <= 1'b0;
				end else if (sample_queue.size() > 0) begin
					drv_item = sample_queue.pop_front();
					samples_if.valid  <= 1'b1;
					samples_if.sample <= drv_item.sample;
					samples_if.last   <= drv_item.last;
					drv_gap = draw_wait(drv_quiet);
				end else begin
					samples_if.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	int mon_stall = 0;
	int mon_quiet = 0;
	norm_result_t mon_exp;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_if.ready <= 1'b0;
		end else begin
			if (results_if.valid && results_if.ready) begin
				if (pending_results.size() == 0) begin
					$error("result transaction with no expectation, index %0d",
						results_if.index);
					fail_count++;
				end else begin
					mon_exp = pending_results.pop_front();
					check_field("index", mon_exp.index, results_if.index);
					check_field("original", mon_exp.original, results_if.original);
					check_field("scaled", mon_exp.scaled, results_if.scaled);
					check_field("mirrored", mon_exp.mirrored, results_if.mirrored);
					check_field("flat_range", mon_exp.flat_range, results_if.flat_range);
					check_field("overflowed", mon_exp.overflowed, results_if.overflowed);
					check_field("final_res", mon_exp.final_res, results_if.final_res);
				end
				mon_stall = draw_wait(mon_quiet);
			end
			if (mon_stall > 0) begin
				mon_stall--;
				results_if.ready <= 1'b0;
			end else begin
				results_if.ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((samples_if.valid && samples_if.ready) ||
				(results_if.valid && results_if.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("min_max_normalize_reverse test failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int size;
		int pick;

		// single sample: min and max both set by it, flat range
		push_item(16'sh0000, 1'b1);
		// full span
		push_item(16'sh8000, 1'b0);
		push_item(16'sh7FFF, 1'b1);
		// extremes in reverse order plus values near zero
		push_item(16'sh7FFF, 1'b0);
		push_item(16'sh8000, 1'b0);
		push_item(16'sh0000, 1'b0);
		push_item(16'sh0001, 1'b0);
		push_item(16'shFFFF, 1'b1);
		// constant set
		push_item(16'sd5, 1'b0);
		push_item(16'sd5, 1'b0);
		push_item(16'sd5, 1'b1);
		push_item(16'sh8000, 1'b1);
		// max then min moved by later samples
		push_item(16'sd100, 1'b0);
		push_item(16'sd200, 1'b0);
		push_item(16'sd150, 1'b0);
		push_item(16'sd50, 1'b0);
		push_item(16'sd300, 1'b1);
		// falling run, only the minimum moves
		push_item(16'sd10, 1'b0);
		push_item(16'sd9, 1'b0);
		push_item(16'sd8, 1'b1);

		// a full store, then one whose last sample is dropped
		queue_random_set(DEPTH);
		queue_random_set(DEPTH + 1);
		while (items_queued < ITEM_COUNT) begin
			pick = $urandom_range(0, 99);
			if (pick < 65)
				size = $urandom_range(1, 8);
			else if (pick < 90)
				size = $urandom_range(9, 40);
			else
				size = $urandom_range(DEPTH - 8, DEPTH + 8);
			queue_random_set(size);
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (sample_queue.size() != 0 || samples_if.valid || pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("min_max_normalize_reverse test passed");
		else
			$display("min_max_normalize_reverse test failed");
		$finish;
	end

endmodule

### files.f
design/mmnr_pkg.sv
design/mmnr_if.sv
design/mmnr_div.sv
design/min_max_normalize_reverse.sv
design/mmnr_checker.sv
dv/tb.sv
